// File: hw/rtl/pmqs_pkg.sv
// Shared types and codes of the priority message queue scheduler.
// Used by every module under hw/rtl except pmqs_ram; depends on nothing.
package pmqs_pkg;

  localparam logic [1:0] MODE_POST     = 2'd0;
  localparam logic [1:0] MODE_DISPATCH = 2'd1;
  localparam logic [1:0] MODE_QUERY    = 2'd2;
  localparam logic [1:0] MODE_SPARE    = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [1:0] CFG_ENABLE_MASK = 2'd0;
  localparam logic [1:0] CFG_TASK_IDS    = 2'd1;
  localparam logic [1:0] CFG_PRIORITIES  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  target_task;
    logic [15:0] message_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle_out;
    logic [7:0]  task_out;
    logic [7:0]  priority_out;
    logic [3:0]  depth_after;
    logic [3:0]  depth_peak;
    logic [31:0] posted_total;
    logic [31:0] dispatched_total;
    logic [31:0] dropped_total;
  } out_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// File: hw/rtl/pmqs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pmqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: hw/rtl/pmqs_ctrl.sv
// Sequencer of the scheduler: accept, execute, report.
// Depends on pmqs_pkg.
module pmqs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  output pmqs_pkg::cmd_t  cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign busy        = (state_r == S_EXEC);
  assign out_valid   = (state_r == S_DONE);
  assign cmd.capture = start && !busy;
  assign cmd.execute = (state_r == S_EXEC);

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = start ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_DONE;
      S_DONE:  state_nxt = start ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// File: hw/rtl/pmqs_dp.sv
// Datapath: configuration, per-slot queue state, lookup, priority pick, result.
// Depends on pmqs_pkg and pmqs_ram.
module pmqs_dp #(
  parameter int TASK_SLOTS  = 8,
  parameter int QUEUE_DEPTH = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pmqs_pkg::cmd_t   cmd,
  input  pmqs_pkg::in_t    in_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_wdata,
  output pmqs_pkg::out_t   out_data
);
  localparam int SW   = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  localparam int SLW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW   = $clog2(QUEUE_DEPTH + 1);
  localparam int MD   = TASK_SLOTS * QUEUE_DEPTH;
  localparam int AW   = (MD > 1) ? $clog2(MD) : 1;

  logic [7:0]  mask_r;
  logic [63:0] ids_r, prios_r;

  logic [1:0]  mode_r;
  logic [7:0]  target_r;
  logic [15:0] handle_r;

  logic [PW-1:0] rp_r   [TASK_SLOTS];
  logic [PW-1:0] wp_r   [TASK_SLOTS];
  logic [FW-1:0] fill_r [TASK_SLOTS];
  logic [FW-1:0] peak_r [TASK_SLOTS];
  logic [31:0]   acc_r  [TASK_SLOTS];
  logic [31:0]   srv_r  [TASK_SLOTS];
  logic [31:0]   ref_r  [TASK_SLOTS];

  logic           match_hit, pick_hit, found, disp, post_ok, post_drop, pop;
  logic [SLW-1:0] match_sel, pick_sel, sel;
  logic [7:0]     best_prio;
  logic [FW-1:0]  fill_nxt, peak_nxt;
  logic [PW-1:0]  rp_nxt, wp_nxt;
  logic [31:0]    acc_nxt, srv_nxt, ref_nxt;
  logic [AW-1:0]  ram_addr;
  logic [SW-1:0]  ram_rdata;
  pmqs_pkg::out_t res_nxt, res_r;
  logic           pop_r;

  // Lookup: lowest enabled slot whose id matches; id zero never matches.
  always_comb begin
    match_hit = 1'b0;
    match_sel = '0;
    for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
      if (mask_r[s] && ids_r[8*s +: 8] == target_r && target_r != 8'd0) begin
        match_hit = 1'b1;
        match_sel = SLW'(s);
      end
    end
  end

  // Pick: highest priority among enabled non-empty slots, lowest slot on ties.
  always_comb begin
    pick_hit  = 1'b0;
    pick_sel  = '0;
    best_prio = 8'd0;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      if (mask_r[s] && fill_r[s] != '0) begin
        if (!pick_hit || prios_r[8*s +: 8] > best_prio) begin
          pick_hit  = 1'b1;
          pick_sel  = SLW'(s);
          best_prio = prios_r[8*s +: 8];
        end
      end
    end
  end

  always_comb begin
    disp      = (mode_r == pmqs_pkg::MODE_DISPATCH);
    sel       = disp ? pick_sel : match_sel;
    found     = disp ? pick_hit : match_hit;
    post_ok   = found && mode_r == pmqs_pkg::MODE_POST &&
                fill_r[sel] != FW'(QUEUE_DEPTH);
    post_drop = found && mode_r == pmqs_pkg::MODE_POST &&
                fill_r[sel] == FW'(QUEUE_DEPTH);
    pop       = found && disp;

    rp_nxt   = (rp_r[sel] == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r[sel] + PW'(1);
    wp_nxt   = (wp_r[sel] == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r[sel] + PW'(1);
    fill_nxt = fill_r[sel];
    if (post_ok) fill_nxt = fill_r[sel] + FW'(1);
    if (pop)     fill_nxt = fill_r[sel] - FW'(1);
    peak_nxt = (fill_nxt > peak_r[sel]) ? fill_nxt : peak_r[sel];
    acc_nxt  = post_ok   ? acc_r[sel] + 32'd1 : acc_r[sel];
    srv_nxt  = pop       ? srv_r[sel] + 32'd1 : srv_r[sel];
    ref_nxt  = post_drop ? ref_r[sel] + 32'd1 : ref_r[sel];

    ram_addr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(disp ? rp_r[sel] : wp_r[sel]);

    res_nxt = '0;
    if (!found) begin
      res_nxt.status   = disp ? pmqs_pkg::ST_EMPTY : pmqs_pkg::ST_UNKNOWN;
      res_nxt.task_out = disp ? 8'd0 : target_r;
    end else begin
      res_nxt.status           = post_drop ? pmqs_pkg::ST_FULL : pmqs_pkg::ST_DONE;
      res_nxt.task_out         = ids_r[8*sel +: 8];
      res_nxt.priority_out     = prios_r[8*sel +: 8];
      res_nxt.depth_after      = 4'(fill_nxt);
      res_nxt.depth_peak       = 4'(peak_nxt);
      res_nxt.posted_total     = acc_nxt;
      res_nxt.dispatched_total = srv_nxt;
      res_nxt.dropped_total    = ref_nxt;
    end
  end

  pmqs_ram #(.WIDTH(SW), .DEPTH(MD)) u_store (
    .clk   (clk),
    .we    (cmd.execute && post_ok),
    .addr  (ram_addr),
    .wdata (SW'(handle_r)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_data.mode;
      target_r <= in_data.target_task;
      handle_r <= in_data.message_handle;
    end
    if (cmd.execute) begin
      res_r <= res_nxt;
      pop_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      ids_r   <= '0;
      prios_r <= '0;
      for (int s = 0; s < TASK_SLOTS; s++) begin
        rp_r[s]   <= '0;
        wp_r[s]   <= '0;
        fill_r[s] <= '0;
        peak_r[s] <= '0;
        acc_r[s]  <= '0;
        srv_r[s]  <= '0;
        ref_r[s]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pmqs_pkg::CFG_ENABLE_MASK: mask_r  <= cfg_wdata[7:0];
          pmqs_pkg::CFG_TASK_IDS:    ids_r   <= cfg_wdata;
          pmqs_pkg::CFG_PRIORITIES:  prios_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.execute && found) begin
        fill_r[sel] <= fill_nxt;
        peak_r[sel] <= peak_nxt;
        acc_r[sel]  <= acc_nxt;
        srv_r[sel]  <= srv_nxt;
        ref_r[sel]  <= ref_nxt;
        if (post_ok) wp_r[sel] <= wp_nxt;
        if (pop)     rp_r[sel] <= rp_nxt;
      end
    end
  end

  always_comb begin
    out_data            = res_r;
    out_data.handle_out = pop_r ? 16'(ram_rdata) : 16'd0;
  end
endmodule

// File: hw/rtl/priority_message_queue_scheduler_core.sv
// Strict-priority multi-queue message scheduler, top level.
// An accepted command goes through the execute state, then its result is strobed in done.
// No command is taken while busy; the next may be taken while a result is strobed. The
// result strobe lasts one cycle and cannot be held. Reset (synchronous, rst_n low) clears
// config registers, control state, pointers and counters, not stored handles or results.
module priority_message_queue_scheduler_core #(
  parameter int TASK_SLOTS  = 8,
  parameter int QUEUE_DEPTH = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pmqs_pkg::in_t   in_data,
  output logic            out_valid,
  output pmqs_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [63:0]     cfg_wdata
);
  pmqs_pkg::cmd_t cmd;

  // Sequence each beat: capture, execute, then strobe the result.
  pmqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Hold queue state, do the lookup or priority pick, and drive the result.
  pmqs_dp #(
    .TASK_SLOTS  (TASK_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  // An accepted beat always goes busy for exactly one cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted beat did not start");
  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy && out_valid) else $error("execute did not end in a result");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result strobe without execute");
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for priority_message_queue_scheduler_core.
// Holds its own scheduler predictor and checks every result beat against it.
// Depends on pmqs_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int DEPTH = 8;
  // Extra slack waited after the last predicted result has been answered.
  localparam int SETTLE_CYCLES = 6;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  pmqs_pkg::in_t  in_data = '0;
  logic           out_valid;
  pmqs_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = pmqs_pkg::CFG_ENABLE_MASK;
  logic [63:0]    cfg_wdata = '0;

  priority_message_queue_scheduler_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the scheduler: registers, per-slot FIFOs and counters.
  logic [7:0]  sh_mask = '0;
  logic [63:0] sh_ids = '0;
  logic [63:0] sh_prios = '0;
  logic [15:0] sh_store [SLOTS][DEPTH];
  logic [2:0]  sh_rd [SLOTS];
  logic [2:0]  sh_wr [SLOTS];
  logic [3:0]  sh_fill [SLOTS];
  logic [3:0]  sh_peak [SLOTS];
  logic [31:0] sh_posted [SLOTS];
  logic [31:0] sh_served [SLOTS];
  logic [31:0] sh_dropped [SLOTS];

  pmqs_pkg::in_t  cmd_backlog [$];    // commands waiting for the driver
  pmqs_pkg::out_t results_due [$];    // predicted result beats, oldest first

  int  errors = 0;
  int  beats_seen = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  bit  idle_allowed = 1'b1;

  function automatic logic [7:0] slot_id(int s);
    return sh_ids[8*s +: 8];
  endfunction

  function automatic logic [7:0] slot_prio(int s);
    return sh_prios[8*s +: 8];
  endfunction

  function automatic pmqs_pkg::out_t slot_report(int s, logic [1:0] st, logic [15:0] h);
    pmqs_pkg::out_t r;
    r.status           = st;
    r.handle_out       = h;
    r.task_out         = slot_id(s);
    r.priority_out     = slot_prio(s);
    r.depth_after      = sh_fill[s];
    r.depth_peak       = sh_peak[s];
    r.posted_total     = sh_posted[s];
    r.dispatched_total = sh_served[s];
    r.dropped_total    = sh_dropped[s];
    return r;
  endfunction

  // Advance the shadow by one command and return the beat it must produce.
  function automatic pmqs_pkg::out_t schedule_step(pmqs_pkg::in_t cmd);
    pmqs_pkg::out_t r;
    int   pick;
    logic [15:0] h;
    r = '0;
    pick = -1;
    if (cmd.mode == pmqs_pkg::MODE_DISPATCH) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (sh_mask[s] && sh_fill[s] != 0) begin
          if (pick < 0 || slot_prio(s) > slot_prio(pick)) pick = s;
        end
      end
      if (pick < 0) begin
        r.status = pmqs_pkg::ST_EMPTY;
      end else begin
        h = sh_store[pick][sh_rd[pick]];
        sh_rd[pick] = sh_rd[pick] + 1;
        sh_fill[pick] = sh_fill[pick] - 1;
        sh_served[pick] = sh_served[pick] + 1;
        r = slot_report(pick, pmqs_pkg::ST_DONE, h);
      end
      return r;
    end
    // Post, query and the unused mode all look the target up; id zero never matches.
    if (cmd.target_task != 0) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (pick < 0 && sh_mask[s] && slot_id(s) == cmd.target_task) pick = s;
      end
    end
    if (pick < 0) begin
      r.status = pmqs_pkg::ST_UNKNOWN;
      r.task_out = cmd.target_task;
    end else if (cmd.mode == pmqs_pkg::MODE_POST) begin
      if (sh_fill[pick] < DEPTH) begin
        sh_store[pick][sh_wr[pick]] = cmd.message_handle;
        sh_wr[pick] = sh_wr[pick] + 1;
        sh_fill[pick] = sh_fill[pick] + 1;
        sh_posted[pick] = sh_posted[pick] + 1;
        if (sh_fill[pick] > sh_peak[pick]) sh_peak[pick] = sh_fill[pick];
        r = slot_report(pick, pmqs_pkg::ST_DONE, 16'h0);
      end else begin
        sh_dropped[pick] = sh_dropped[pick] + 1;
        r = slot_report(pick, pmqs_pkg::ST_FULL, 16'h0);
      end
    end else begin
      r = slot_report(pick, pmqs_pkg::ST_DONE, 16'h0);
    end
    return r;
  endfunction

  // Driver: a beat is taken when start is high and busy low at the edge.
  always @(posedge clk) begin
    bit taken;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) results_due.push_back(schedule_step(in_data));
      if (!start || taken) begin
        // Insert a random gap, otherwise launch the next pending command.
        if (cmd_backlog.size() != 0 &&
            !(idle_allowed && $urandom_range(0, 99) < 27)) begin
          start   <= 1'b1;
          in_data <= cmd_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, name, want, got);
    end
  endtask

  // Monitor: every strobed beat is matched against the oldest prediction.
  always @(posedge clk) begin
    pmqs_pkg::out_t want;
    if (rst_n && out_valid) begin
      beats_seen++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %0h",
                 $realtime, out_data);
      end else begin
        want = results_due.pop_front();
        status_seen[want.status]++;
        check_field("status", want.status, out_data.status);
        check_field("handle_out", want.handle_out, out_data.handle_out);
        check_field("task_out", want.task_out, out_data.task_out);
        check_field("priority_out", want.priority_out, out_data.priority_out);
        check_field("depth_after", want.depth_after, out_data.depth_after);
        check_field("depth_peak", want.depth_peak, out_data.depth_peak);
        check_field("posted_total", want.posted_total, out_data.posted_total);
        check_field("dispatched_total", want.dispatched_total, out_data.dispatched_total);
        check_field("dropped_total", want.dropped_total, out_data.dropped_total);
      end
    end
  end

  function automatic pmqs_pkg::in_t make_cmd(logic [1:0] m, logic [7:0] t, logic [15:0] h);
    pmqs_pkg::in_t c;
    c.mode = m;
    c.target_task = t;
    c.message_handle = h;
    return c;
  endfunction

  // Hold until the driver is empty and every prediction has been answered.
  task automatic drain();
    while (cmd_backlog.size() != 0 || start || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == pmqs_pkg::CFG_ENABLE_MASK) sh_mask = val[7:0];
    else if (idx == pmqs_pkg::CFG_TASK_IDS) sh_ids = val;
    else if (idx == pmqs_pkg::CFG_PRIORITIES) sh_prios = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_slots(logic [7:0] m, logic [63:0] ids, logic [63:0] pr);
    write_reg(pmqs_pkg::CFG_ENABLE_MASK, {56'h0, m});
    write_reg(pmqs_pkg::CFG_TASK_IDS, ids);
    write_reg(pmqs_pkg::CFG_PRIORITIES, pr);
  endtask

  // Random traffic: mostly posts and dispatches to configured ids, some noise.
  task automatic queue_random(int count);
    logic [1:0] m;
    logic [7:0] t;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      m = (r < 48) ? pmqs_pkg::MODE_POST : (r < 88) ? pmqs_pkg::MODE_DISPATCH :
          (r < 95) ? pmqs_pkg::MODE_QUERY : pmqs_pkg::MODE_SPARE;
      t = ($urandom_range(0, 99) < 85) ? sh_ids[8*$urandom_range(0, 7) +: 8]
                                        : 8'($urandom_range(0, 255));
      cmd_backlog.push_back(make_cmd(m, t, 16'($urandom_range(0, 65535))));
    end
  endtask

  function automatic logic [63:0] random_bytes(int lo, int hi);
    logic [63:0] v;
    for (int s = 0; s < SLOTS; s++) v[8*s +: 8] = 8'($urandom_range(lo, hi));
    return v;
  endfunction

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      sh_rd[s] = '0; sh_wr[s] = '0; sh_fill[s] = '0; sh_peak[s] = '0;
      sh_posted[s] = '0; sh_served[s] = '0; sh_dropped[s] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: nothing registered, so posts and the unused mode miss and dispatch finds nothing.
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_POST, 8'h00, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_DISPATCH, 8'h00, 16'h0000));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_SPARE, 8'hFF, 16'h0000));
    drain();

    // Slots 0 and 3 share id 0xFF (lowest wins); slot 7 has id zero; priorities tie.
    set_slots(8'hFF, 64'h00_06_05_04_FF_02_01_FF, 64'h00_00_00_00_00_00_00_00);
    for (int i = 0; i < 9; i++)   // ninth post overflows and is dropped
      cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_POST, 8'hFF,
                                     (i == 0) ? 16'hFFFF : 16'(i)));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_POST, 8'h00, 16'h1234));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_POST, 8'h02, 16'h0000));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_QUERY, 8'hFF, 16'h0000));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_SPARE, 8'h02, 16'hAAAA));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_DISPATCH, 8'h00, 16'h0000));  // tie: slot 0
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_DISPATCH, 8'h00, 16'h0000));
    drain();
    // Disable slot 0 and raise slot 2 above all: slot 0's messages stay but sit idle.
    set_slots(8'hFE, 64'h00_06_05_04_FF_02_01_FF, 64'h00_00_00_00_00_FF_00_00);
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_DISPATCH, 8'h00, 16'h0000));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_DISPATCH, 8'h00, 16'h0000));
    cmd_backlog.push_back(make_cmd(pmqs_pkg::MODE_QUERY, 8'hFF, 16'h0000));
    drain();

    // Random phases; the first ones use extreme register settings.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_slots(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        1: set_slots(8'h00, random_bytes(0, 255), random_bytes(0, 255));
        2: set_slots(8'hFF, 64'h0807_0605_0403_0201, 64'h0001_0203_FF05_0607);
        default: set_slots(8'($urandom_range(0, 255)),
                           ($urandom_range(0, 3) == 0) ? random_bytes(0, 255)
                                                       : random_bytes(0, 9),
                           random_bytes(0, ($urandom_range(0, 1) != 0) ? 3 : 255));
      endcase
      idle_allowed = (ph != 5);   // one phase runs back to back
      queue_random(135);
      drain();
    end

    if (results_due.size() != 0) errors++;
    $display("Run covered %0d result beats: done %0d, unknown task %0d, dropped %0d,",
             beats_seen, status_seen[pmqs_pkg::ST_DONE], status_seen[pmqs_pkg::ST_UNKNOWN],
             status_seen[pmqs_pkg::ST_FULL]);
    $display("nothing pending %0d, across 15 register settings with random gaps.",
             status_seen[pmqs_pkg::ST_EMPTY]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pmqs_pkg.sv
hw/rtl/pmqs_ram.sv
hw/rtl/pmqs_ctrl.sv
hw/rtl/pmqs_dp.sv
hw/rtl/priority_message_queue_scheduler_core.sv
tb/tb_top.sv
